>>> rtl/fdi_pkg.sv
// shared types, constants and helpers for the feedback delay block
`timescale 1ns / 1ps
package fdi_pkg;

    localparam int BUFFER_DEPTH_DEF = 131072;

    localparam int AUDIO_W  = 24;
    localparam int MOD_W    = 16;
    localparam int BASE_W   = 33;
    localparam int DEPTH_W  = 24;
    localparam int COEFF_W  = 16;
    localparam int GAIN_W   = 17;
    localparam int CFG_W    = 33;
    localparam int CFG_IDX_W = 3;
    localparam int SMOOTH_W = 40;
    localparam int TARGET_W = 34;

    localparam logic [GAIN_W-1:0] ONE_Q16      = 17'd65536;
    localparam logic [15:0]       FB_SCALE_Q16 = 16'd62259;

    localparam logic [DEPTH_W-1:0] MOD_DEPTH_RST    = 24'd6291456;
    localparam logic [COEFF_W-1:0] SMOOTH_COEFF_RST = 16'd655;
    localparam logic [GAIN_W-1:0]  WET_RST          = 17'd32768;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BASE_DELAY = 3'd0,
        REG_MOD_DEPTH  = 3'd1,
        REG_SMOOTH     = 3'd2,
        REG_FEEDBACK   = 3'd3,
        REG_WET        = 3'd4
    } fdi_reg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MODMUL,
        ST_TARGET,
        ST_SMMUL,
        ST_SMUPD,
        ST_ADDR,
        ST_RD0,
        ST_RD1,
        ST_INTERP,
        ST_READ,
        ST_STORE,
        ST_MIX,
        ST_OUT
    } fdi_state_t;

    typedef struct packed {
        logic load_in;
        logic mod_mul;
        logic target;
        logic sm_mul;
        logic sm_upd;
        logic addr;
        logic rd0;
        logic rd1;
        logic interp;
        logic rd_calc;
        logic store;
        logic mix;
        logic out_load;
    } fdi_cmd_t;

    function automatic logic signed [AUDIO_W-1:0] sat24(input logic signed [42:0] v);
        logic signed [42:0] hi;
        logic signed [42:0] lo;
        hi = 43'sd8388607;
        lo = -43'sd8388608;
        if (v > hi)
            sat24 = 24'sh7FFFFF;
        else if (v < lo)
            sat24 = 24'sh800000;
        else
            sat24 = v[AUDIO_W-1:0];
    endfunction

endpackage

>>> rtl/fdi_in_if.sv
// input channel: audio and modulation sample per beat
`timescale 1ns / 1ps
interface fdi_in_if;
    logic               valid;
    logic               ready;
    logic signed [23:0] audio_in;
    logic signed [15:0] mod_in;

    modport source (output valid, output audio_in, output mod_in, input ready);
    modport sink (input valid, input audio_in, input mod_in, output ready);
endinterface

>>> rtl/fdi_out_if.sv
// output channel: mixed audio sample per beat
`timescale 1ns / 1ps
interface fdi_out_if;
    logic               valid;
    logic               ready;
    logic signed [23:0] audio_out;

    modport source (output valid, output audio_out, input ready);
    modport sink (input valid, input audio_out, output ready);
endinterface

>>> rtl/feedback_delay_interp_core.sv
// top level of the modulated feedback delay with interpolated read
`timescale 1ns / 1ps
// Usage:
//   in_ch carries one audio_in / mod_in pair per beat; out_ch returns one
//   mixed audio_out sample per accepted beat, in order.
//   Configuration is a plain write port (cfg_we, cfg_index, cfg_data);
//   registers: 0 base_delay, 1 mod_depth, 2 smooth_coeff,
//   3 feedback_amount, 4 wet_amount. Write only while the block is idle.
// Sequence:
//   a sample walks a 12-step sequence (target multiply, smoothing multiply,
//   two single-port buffer reads, interpolation, feedback and mix
//   multiplies) from accept to out_ch.valid; a new sample is taken only
//   once the sequencer is back in idle, so samples are computed one at a time.
// Reset:
//   rst_n clears write position, smoothed delay, last read and the
//   registers to their defaults; buffer slots not yet written since reset
//   read as zero through a write-position fill mark, so no clearing pass.
// Stall:
//   the result sits in an output register; one more sample may be taken
//   and computed while it waits, then the sequencer holds in its last step.
module feedback_delay_interp_core
#(
    parameter int BUFFER_DEPTH = fdi_pkg::BUFFER_DEPTH_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    fdi_in_if.sink                        in_ch,
    fdi_out_if.source                     out_ch,
    input  logic                          cfg_we,
    input  logic [fdi_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [fdi_pkg::CFG_W-1:0]     cfg_data
);
    import fdi_pkg::*;

    fdi_cmd_t cmd;

    fdi_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .cmd       (cmd)
    );

    fdi_datapath #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .audio_in  (in_ch.audio_in),
        .mod_in    (in_ch.mod_in),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .audio_out (out_ch.audio_out)
    );

endmodule

>>> rtl/fdi_ctrl.sv
// sequencer for one sample: issues datapath steps and owns the handshakes
`timescale 1ns / 1ps
module fdi_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    output fdi_pkg::fdi_cmd_t cmd
);
    import fdi_pkg::*;

    fdi_state_t state_reg, state_next;
    logic       out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_MODMUL;
                end
            end
            ST_MODMUL:
            begin
                cmd.mod_mul = 1'b1;
                state_next  = ST_TARGET;
            end
            ST_TARGET:
            begin
                cmd.target = 1'b1;
                state_next = ST_SMMUL;
            end
            ST_SMMUL:
            begin
                cmd.sm_mul = 1'b1;
                state_next = ST_SMUPD;
            end
            ST_SMUPD:
            begin
                cmd.sm_upd = 1'b1;
                state_next = ST_ADDR;
            end
            ST_ADDR:
            begin
                cmd.addr   = 1'b1;
                state_next = ST_RD0;
            end
            ST_RD0:
            begin
                cmd.rd0    = 1'b1;
                state_next = ST_RD1;
            end
            ST_RD1:
            begin
                cmd.rd1    = 1'b1;
                state_next = ST_INTERP;
            end
            ST_INTERP:
            begin
                cmd.interp = 1'b1;
                state_next = ST_READ;
            end
            ST_READ:
            begin
                cmd.rd_calc = 1'b1;
                state_next  = ST_STORE;
            end
            ST_STORE:
            begin
                cmd.store  = 1'b1;
                state_next = ST_MIX;
            end
            ST_MIX:
            begin
                cmd.mix    = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                // hold the result until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || out_ready))
        else $error("result loaded over an untaken beat");

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == ST_MODMUL))
        else $error("accepted beat did not start a sample");

    a_valid_rise: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == ST_OUT))
        else $error("output valid rose outside the output step");

    a_store_once: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.store |=> !cmd.store)
        else $error("buffer written twice for one sample");

endmodule

>>> rtl/fdi_datapath.sv
// arithmetic, configuration registers and ring buffer of the delay line
`timescale 1ns / 1ps
module fdi_datapath
#(
    parameter int BUFFER_DEPTH = fdi_pkg::BUFFER_DEPTH_DEF
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  fdi_pkg::fdi_cmd_t                cmd,
    input  logic signed [23:0]               audio_in,
    input  logic signed [15:0]               mod_in,
    input  logic                             cfg_we,
    input  logic [fdi_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [fdi_pkg::CFG_W-1:0]        cfg_data,
    output logic signed [23:0]               audio_out
);
    import fdi_pkg::*;

    localparam int AW = $clog2(BUFFER_DEPTH);
    localparam logic [AW-1:0]       LAST_ADDR = AW'(BUFFER_DEPTH - 1);
    localparam logic [AW:0]         DEPTH_EXT = (AW+1)'(BUFFER_DEPTH);
    localparam logic [SMOOTH_W-1:0] MAX_DELAY = SMOOTH_W'(BUFFER_DEPTH - 1) << 16;
    localparam logic [SMOOTH_W-1:0] SMOOTH_MAX = '1;

    // configuration
    logic [BASE_W-1:0]  base_delay_reg;
    logic [DEPTH_W-1:0] mod_depth_reg;
    logic [COEFF_W-1:0] smooth_coeff_reg;
    logic [GAIN_W-1:0]  feedback_reg;
    logic [GAIN_W-1:0]  wet_reg;

    // state
    logic [AW-1:0]           wp_reg;
    logic                    wrapped_reg;
    logic [SMOOTH_W-1:0]     smoothed_reg;
    logic signed [23:0]      last_read_reg;

    // per-sample payload
    logic signed [23:0]      x_reg;
    logic signed [15:0]      mod_reg;
    logic signed [40:0]      mod_prod_reg;
    logic [15:0]             fbs_reg;
    logic [GAIN_W-1:0]       wet_c_reg;
    logic [TARGET_W-1:0]     target_reg;
    logic signed [57:0]      sm_prod_reg;
    logic [AW-1:0]           a0_reg;
    logic [15:0]             frac_reg;
    logic signed [23:0]      mem [BUFFER_DEPTH];
    logic signed [23:0]      mem_q_reg;
    logic                    mem_ok_reg;
    logic signed [23:0]      y0_reg;
    logic signed [41:0]      ip_prod_reg;
    logic signed [23:0]      rd_reg;
    logic signed [40:0]      fb_prod_reg;
    logic signed [41:0]      mix_a_reg;
    logic signed [41:0]      mix_b_reg;
    logic signed [23:0]      out_reg;

    logic [GAIN_W-1:0]       fb_c;
    logic [32:0]             fb_full;
    logic signed [34:0]      target_s;
    logic signed [40:0]      diff;
    logic signed [42:0]      sm_sum;
    logic [SMOOTH_W-1:0]     sm_next;
    logic [SMOOTH_W-1:0]     d_cl;
    logic [AW-1:0]           dint;
    logic [AW:0]             a0_diff;
    logic [AW-1:0]           a0_next;
    logic [AW-1:0]           a1;
    logic signed [23:0]      y_sel;
    logic signed [24:0]      dy;
    logic signed [25:0]      rd_sum;
    logic signed [42:0]      st_sum;
    logic signed [42:0]      mix_sum;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_delay_reg   <= '0;
            mod_depth_reg    <= MOD_DEPTH_RST;
            smooth_coeff_reg <= SMOOTH_COEFF_RST;
            feedback_reg     <= '0;
            wet_reg          <= WET_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_BASE_DELAY: base_delay_reg   <= cfg_data;
                REG_MOD_DEPTH:  mod_depth_reg    <= cfg_data[DEPTH_W-1:0];
                REG_SMOOTH:     smooth_coeff_reg <= cfg_data[COEFF_W-1:0];
                REG_FEEDBACK:   feedback_reg     <= cfg_data[GAIN_W-1:0];
                REG_WET:        wet_reg          <= cfg_data[GAIN_W-1:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        fb_c     = (feedback_reg > ONE_Q16) ? ONE_Q16 : feedback_reg;
        fb_full  = 33'(fb_c) * 33'(FB_SCALE_Q16) + 33'd32768;
        target_s = $signed({2'b00, base_delay_reg}) + 35'(mod_prod_reg >>> 15);
        diff     = $signed({1'b0, target_reg}) - $signed({1'b0, smoothed_reg});
        sm_sum   = $signed({3'b000, smoothed_reg}) + 43'(sm_prod_reg >>> 16);
        if (sm_sum < 0)
            sm_next = '0;
        else if (sm_sum > $signed({3'b000, SMOOTH_MAX}))
            sm_next = SMOOTH_MAX;
        else
            sm_next = sm_sum[SMOOTH_W-1:0];
        d_cl     = (smoothed_reg > MAX_DELAY) ? MAX_DELAY : smoothed_reg;
        dint     = d_cl[16 +: AW];
        a0_diff  = {1'b0, wp_reg} - {1'b0, dint};
        // wrap the tap back into the ring when the delay reaches past slot zero
        a0_next  = a0_diff[AW] ? AW'(a0_diff + DEPTH_EXT) : a0_diff[AW-1:0];
        a1       = (a0_reg == '0) ? LAST_ADDR : a0_reg - 1'b1;
        y_sel    = mem_ok_reg ? mem_q_reg : '0;
        dy       = 25'(y_sel) - 25'(y0_reg);
        rd_sum   = 26'(y0_reg) + 26'(ip_prod_reg >>> 16);
        st_sum   = 43'(x_reg) + 43'(fb_prod_reg >>> 16);
        mix_sum  = (43'(mix_a_reg) + 43'(mix_b_reg)) >>> 16;
    end

    // control state with defined reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg        <= '0;
            wrapped_reg   <= 1'b0;
            smoothed_reg  <= '0;
            last_read_reg <= '0;
        end
        else
        begin
            if (cmd.sm_upd)
                smoothed_reg <= sm_next;
            if (cmd.store)
            begin
                last_read_reg <= rd_reg;
                if (wp_reg == LAST_ADDR)
                begin
                    wp_reg      <= '0;
                    wrapped_reg <= 1'b1;
                end
                else
                begin
                    wp_reg <= wp_reg + 1'b1;
                end
            end
        end
    end

    // ring buffer; slots not yet written since reset read as zero
    always_ff @(posedge clk)
    begin
        if (cmd.store)
            mem[wp_reg] <= sat24(st_sum);
        if (cmd.rd0)
        begin
            mem_q_reg  <= mem[a0_reg];
            mem_ok_reg <= wrapped_reg || (a0_reg < wp_reg);
        end
        else if (cmd.rd1)
        begin
            mem_q_reg  <= mem[a1];
            mem_ok_reg <= wrapped_reg || (a1 < wp_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            x_reg   <= audio_in;
            mod_reg <= mod_in;
        end
        if (cmd.mod_mul)
        begin
            mod_prod_reg <= 41'(mod_reg) * $signed({1'b0, mod_depth_reg});
            fbs_reg      <= fb_full[31:16];
            wet_c_reg    <= (wet_reg > ONE_Q16) ? ONE_Q16 : wet_reg;
        end
        if (cmd.target)
            target_reg <= (target_s < 0) ? '0 : target_s[TARGET_W-1:0];
        if (cmd.sm_mul)
            sm_prod_reg <= 58'(diff) * $signed({1'b0, smooth_coeff_reg});
        if (cmd.addr)
        begin
            a0_reg   <= a0_next;
            frac_reg <= d_cl[15:0];
        end
        if (cmd.rd1)
            y0_reg <= y_sel;
        if (cmd.interp)
            ip_prod_reg <= 42'(dy) * $signed({1'b0, frac_reg});
        if (cmd.rd_calc)
        begin
            rd_reg      <= rd_sum[23:0];
            fb_prod_reg <= 41'(last_read_reg) * $signed({1'b0, fbs_reg});
        end
        if (cmd.store)
            mix_a_reg <= 42'(x_reg) * $signed({1'b0, ONE_Q16 - wet_c_reg});
        if (cmd.mix)
            mix_b_reg <= 42'(rd_reg) * $signed({1'b0, wet_c_reg});
        if (cmd.out_load)
            out_reg <= sat24(mix_sum);
    end

    assign audio_out = out_reg;

endmodule

>>> tb/tb.sv
// testbench for the modulated feedback delay core: scoreboard, stimulus and checks
`timescale 1ns / 1ps
class fdi_delay_scoreboard;
    localparam int DEPTH = fdi_pkg::BUFFER_DEPTH_DEF;
    localparam longint SMOOTH_MAX = (64'sd1 <<< 40) - 1;

    longint base_delay;
    longint mod_depth;
    longint smooth_coeff;
    longint feedback_amount;
    longint wet_amount;

    int     delay_line [DEPTH];
    int     write_pos;
    longint smoothed;
    longint prev_read;

    logic signed [23:0] expected_out [$];
    int errors;

    function new();
        base_delay      = 0;
        mod_depth       = fdi_pkg::MOD_DEPTH_RST;
        smooth_coeff    = fdi_pkg::SMOOTH_COEFF_RST;
        feedback_amount = 0;
        wet_amount      = fdi_pkg::WET_RST;
        foreach (delay_line[i]) delay_line[i] = 0;
        write_pos = 0;
        smoothed  = 0;
        prev_read = 0;
        errors    = 0;
    endfunction

    function void set_reg(logic [fdi_pkg::CFG_IDX_W-1:0] idx, logic [fdi_pkg::CFG_W-1:0] val);
        case (idx)
            fdi_pkg::REG_BASE_DELAY: base_delay      = longint'(val);
            fdi_pkg::REG_MOD_DEPTH:  mod_depth       = longint'(val[23:0]);
            fdi_pkg::REG_SMOOTH:     smooth_coeff    = longint'(val[15:0]);
            fdi_pkg::REG_FEEDBACK:   feedback_amount = longint'(val[16:0]);
            fdi_pkg::REG_WET:        wet_amount      = longint'(val[16:0]);
            default: ;
        endcase
    endfunction

    function longint clip24(longint v);
        if (v > 8388607) return 8388607;
        if (v < -8388608) return -8388608;
        return v;
    endfunction

    function int tap_at(longint k);
        return delay_line[(write_pos + DEPTH - int'(k % DEPTH)) % DEPTH];
    endfunction

    function void note_input(logic signed [23:0] audio, logic signed [15:0] mod);
        longint x, m, target, dd, di, fr, y0, y1, rd, fb, w, mix;
        x = audio;
        m = mod;
        target = base_delay + ((m * mod_depth) >>> 15);
        if (target < 0) target = 0;
        if (target > SMOOTH_MAX) target = SMOOTH_MAX;
        smoothed = smoothed + (((target - smoothed) * smooth_coeff) >>> 16);
        if (smoothed < 0) smoothed = 0;
        if (smoothed > SMOOTH_MAX) smoothed = SMOOTH_MAX;
        dd = smoothed;
        if (dd > (longint'(DEPTH - 1) <<< 16)) dd = longint'(DEPTH - 1) <<< 16;
        di = dd >>> 16;
        fr = dd & 64'hFFFF;
        y0 = tap_at(di);
        y1 = tap_at(di + 1);
        rd = y0 + (((y1 - y0) * fr) >>> 16);
        fb = (feedback_amount > 65536) ? 65536 : feedback_amount;
        fb = (fb * 62259 + 32768) >>> 16;
        delay_line[write_pos] = int'(clip24(x + ((prev_read * fb) >>> 16)));
        prev_read = clip24(rd);
        w = (wet_amount > 65536) ? 65536 : wet_amount;
        mix = (x * (65536 - w) + rd * w) >>> 16;
        expected_out.push_back(24'(clip24(mix)));
        write_pos = (write_pos + 1) % DEPTH;
    endfunction

    function void check_result(logic signed [23:0] actual);
        logic signed [23:0] exp_val;
        if (expected_out.size() == 0) begin
            $error("audio_out: unexpected beat, actual %0d", actual);
            errors++;
            return;
        end
        exp_val = expected_out.pop_front();
        if (actual !== exp_val) begin
            $error("audio_out: expected %0d actual %0d", exp_val, actual);
            errors++;
        end
    endfunction

    function int pending();
        return expected_out.size();
    endfunction
endclass

module tb;
    import fdi_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0] cfg_data;
    logic no_idle;

    fdi_in_if  in_ch();
    fdi_out_if out_ch();

    fdi_delay_scoreboard sb;

    feedback_delay_interp_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // receiver stalls at random except in the no-idle stretch
    always @(negedge clk)
    begin
        out_ch.ready <= no_idle ? 1'b1 : ($urandom_range(99) >= 33);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
            sb.check_result(out_ch.audio_out);
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        sb.set_reg(idx, val);
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    task automatic send_sample(logic signed [23:0] audio, logic signed [15:0] mod);
        while (!no_idle && $urandom_range(99) < 33)
        begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid    <= 1'b1;
        in_ch.audio_in <= audio;
        in_ch.mod_in   <= mod;
        do
            @(posedge clk);
        while (!in_ch.ready);
        sb.note_input(audio, mod);
        @(negedge clk);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    task automatic random_samples(int count);
        for (int i = 0; i < count; i++)
        begin
            if (i == 40) no_idle = 1'b1;
            if (i == 70) no_idle = 1'b0;
            send_sample(24'($urandom), 16'($urandom));
        end
    endtask

    initial
    begin
        #2000000;
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        sb = new();
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        no_idle = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.audio_in = '0;
        in_ch.mod_in = '0;
        out_ch.ready = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: field extremes, negative target, zero delay, defaults
        send_sample(24'sh7FFFFF, 16'sh7FFF);
        send_sample(24'sh800000, 16'sh8000);
        send_sample(24'sh000000, 16'sh0000);
        send_sample(24'sh7FFFFF, 16'sh8000);
        send_sample(24'sh800000, 16'sh7FFF);
        drain();
        // fast smoothing, full feedback and wet, zero delay
        write_reg(REG_SMOOTH, 33'd65535);
        write_reg(REG_MOD_DEPTH, 33'd0);
        write_reg(REG_FEEDBACK, 33'd65536);
        write_reg(REG_WET, 33'd65536);
        for (int i = 0; i < 6; i++)
            send_sample(i[0] ? 24'sh7FFFFF : 24'sh800000, 16'sh0000);
        drain();
        // negative target clamps at zero delay
        write_reg(REG_MOD_DEPTH, 33'd65536);
        send_sample(24'sh123456, 16'sh8000);
        send_sample(24'sh654321, 16'sh8000);
        drain();
        // delay beyond the buffer and gains above one
        write_reg(REG_BASE_DELAY, 33'h1FFFFFFFF);
        write_reg(REG_MOD_DEPTH, 33'hFFFFFF);
        write_reg(REG_FEEDBACK, 33'h1FFFF);
        write_reg(REG_WET, 33'h1FFFF);
        write_reg(REG_SPARE, 33'h155555555);
        for (int i = 0; i < 6; i++)
            send_sample(24'($urandom), i[0] ? 16'sh7FFF : 16'sh8000);
        drain();

        // short fractional delay with feedback
        write_reg(REG_BASE_DELAY, 33'h0000_5_8000);
        write_reg(REG_MOD_DEPTH, 33'h03_0000);
        write_reg(REG_SMOOTH, 33'd30000);
        write_reg(REG_FEEDBACK, 33'd40000);
        write_reg(REG_WET, 33'd20000);
        random_samples(100);
        drain();

        write_reg(REG_BASE_DELAY, 33'h0002_1234);
        write_reg(REG_MOD_DEPTH, 33'hAA_5555);
        write_reg(REG_SMOOTH, 33'd65535);
        write_reg(REG_FEEDBACK, 33'd65536);
        write_reg(REG_WET, 33'd65536);
        random_samples(100);
        drain();

        write_reg(REG_BASE_DELAY, 33'h0_0000_0000);
        write_reg(REG_MOD_DEPTH, 33'h55_AAAA);
        write_reg(REG_SMOOTH, 33'd0);
        write_reg(REG_FEEDBACK, 33'd0);
        write_reg(REG_WET, 33'd0);
        random_samples(100);
        drain();

        write_reg(REG_BASE_DELAY, 33'h0_000C_4321);
        write_reg(REG_MOD_DEPTH, 33'h08_0000);
        write_reg(REG_SMOOTH, 33'd8000);
        write_reg(REG_FEEDBACK, 33'd60000);
        write_reg(REG_WET, 33'd50000);
        random_samples(100);
        drain();

        if (sb.errors == 0 && sb.pending() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
